// File: hw/rtl/tcw_pkg.sv
// ============================================================================
// tcw_pkg
// Shared types and constants of the text console writer: op codes, command
// kinds passed from the front end to the back end, and character codes.
// ============================================================================
`default_nettype none

package tcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Command queue depth between front and back end
    localparam int QUEUE_DEPTH = 2;

    // Character and color codes
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] BLANK_CODE   = 8'd32;
    localparam logic [7:0] RESET_COLOR  = 8'h0F;

    // Input op codes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Register byte addresses
    localparam logic [1:0] ADDR_TEXT_COLOR = 2'd0;

    // Command kinds after classification
    typedef enum logic [2:0] {
        K_NOP     = 3'd0,
        K_PUT     = 3'd1,
        K_NEWLINE = 3'd2,
        K_CLEAR   = 3'd3,
        K_READ    = 3'd4
    } kind_t;

    // Classified command
    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_code;
        logic [4:0] row;
        logic [6:0] col;
    } cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/tcw_front.sv
// ============================================================================
// tcw_front
// Accepts input items, classifies them into commands (put, newline, clear,
// in-range read, no-op) and hands them to the command queue.
// ============================================================================
`default_nettype none

module tcw_front #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          valid,
    output logic               stall,
    input  wire logic [1:0]    op,
    input  wire logic [7:0]    char_code,
    input  wire logic [4:0]    read_row,
    input  wire logic [6:0]    read_col,
    input  wire logic          hold,
    input  wire logic          queue_full,
    output logic               push,
    output tcw_pkg::cmd_t      push_cmd
);

    logic          vld_reg;
    logic          vld_next;
    tcw_pkg::cmd_t cmd_reg;
    tcw_pkg::cmd_t cls;
    logic          in_range;
    logic          accept;

    // Classify the incoming item
    always_comb
    begin
        in_range      = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);
        cls.kind      = tcw_pkg::K_NOP;
        cls.char_code = char_code;
        cls.row       = read_row;
        cls.col       = read_col;
        case (op)
            tcw_pkg::OP_PUT:
            begin
                if (char_code == tcw_pkg::NEWLINE_CODE)
                begin
                    cls.kind = tcw_pkg::K_NEWLINE;
                end
                else
                begin
                    cls.kind = tcw_pkg::K_PUT;
                end
            end
            tcw_pkg::OP_CLEAR:
            begin
                cls.kind = tcw_pkg::K_CLEAR;
            end
            tcw_pkg::OP_READ:
            begin
                if (in_range)
                begin
                    cls.kind = tcw_pkg::K_READ;
                end
            end
            default:
            begin
                cls.kind = tcw_pkg::K_NOP;
            end
        endcase
    end

    // Hand off when the queue has room; accept unless held or the stage waits on a full queue
    assign push     = vld_reg && !queue_full;
    assign stall    = hold || (vld_reg && queue_full);
    assign accept   = valid && !stall;
    assign push_cmd = cmd_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (push)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Hold the classified command
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cls;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tcw_cmd_queue.sv
// ============================================================================
// tcw_cmd_queue
// Short command queue between the front end and the back end, so either
// side can stall without stopping the other.
// ============================================================================
`default_nettype none

module tcw_cmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire tcw_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output tcw_pkg::cmd_t      head_cmd,
    output logic               not_empty
);

    localparam int DEPTH = tcw_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [NW-1:0] CNT_FULL = NW'(DEPTH);

    tcw_pkg::cmd_t  slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [NW-1:0]  cnt_reg;
    logic [NW-1:0]  cnt_next;
    logic           do_push;
    logic           do_pop;

    assign full      = (cnt_reg == CNT_FULL);
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tcw_back.sv
// ============================================================================
// tcw_back
// Executes commands against the cell store: character writes, newline with
// scroll, screen clear and cell reads. Owns the cursor, the reset clearing
// pass and the result register.
// ============================================================================
`default_nettype none

module tcw_back #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tcw_pkg::cmd_t cmd,
    input  wire logic          cmd_vld,
    output logic               cmd_pop,
    input  wire logic [7:0]    text_color,
    output logic               init_busy,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         cell_char,
    output logic [7:0]         cell_attr,
    output logic [4:0]         cursor_row,
    output logic [6:0]         cursor_col
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS + 1);

    localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
    localparam logic [AW-1:0] BOTTOM_BASE = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0] SPAN_LAST   = AW'((ROWS - 1) * COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST    = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_END     = CW'(COLUMNS);

    typedef enum logic [8:0] {
        S_INIT      = 9'b000000001,
        S_IDLE      = 9'b000000010,
        S_READ      = 9'b000000100,
        S_CLEAR     = 9'b000001000,
        S_COPY      = 9'b000010000,
        S_COPY_LAST = 9'b000100000,
        S_BLANK     = 9'b001000000,
        S_PEND      = 9'b010000000,
        S_RESP      = 9'b100000000
    } state_t;

    logic [15:0]    mem [CELLS];

    state_t         state_reg, state_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [AW-1:0]  row_base_reg, row_base_next;
    logic [AW-1:0]  cnt_reg, cnt_next;
    logic           cp_vld_reg, cp_vld_next;
    logic [AW-1:0]  cp_addr_reg, cp_addr_next;
    logic           pend_reg, pend_next;
    logic [7:0]     pend_char_reg, pend_char_next;
    logic [7:0]     resp_char_reg, resp_char_next;
    logic [7:0]     resp_attr_reg, resp_attr_next;
    logic [15:0]    rd_data_reg;
    logic           out_vld_reg, out_vld_next;
    logic [7:0]     out_char_reg, out_char_next;
    logic [7:0]     out_attr_reg, out_attr_next;
    logic [4:0]     out_row_reg, out_row_next;
    logic [6:0]     out_col_reg, out_col_next;

    logic           we;
    logic [AW-1:0]  waddr;
    logic [15:0]    wdata;
    logic [AW-1:0]  raddr;
    logic           out_free;
    logic           load;
    logic [7:0]     ld_char;
    logic [7:0]     ld_attr;

    assign out_free   = !out_vld_reg || !out_stall;
    assign init_busy  = (state_reg == S_INIT);
    assign out_valid  = out_vld_reg;
    assign cell_char  = out_char_reg;
    assign cell_attr  = out_attr_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;

    // Sequence commands over the cell store
    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        row_base_next  = row_base_reg;
        cnt_next       = cnt_reg;
        cp_vld_next    = 1'b0;
        cp_addr_next   = cnt_reg;
        pend_next      = pend_reg;
        pend_char_next = pend_char_reg;
        resp_char_next = resp_char_reg;
        resp_attr_next = resp_attr_reg;
        cmd_pop        = 1'b0;
        load           = 1'b0;
        ld_char        = 8'd0;
        ld_attr        = 8'd0;
        we             = 1'b0;
        waddr          = cnt_reg;
        wdata          = {tcw_pkg::BLANK_CODE, text_color};
        raddr          = AW'(cmd.row) * COLS_A + AW'(cmd.col);

        // Retire the copy read from the previous cycle
        if (cp_vld_reg)
        begin
            we    = 1'b1;
            waddr = cp_addr_reg;
            wdata = rd_data_reg;
        end

        case (state_reg)
            S_INIT:
            begin
                we    = 1'b1;
                waddr = cnt_reg;
                wdata = {tcw_pkg::BLANK_CODE, tcw_pkg::RESET_COLOR};
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (cmd_vld && out_free)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        tcw_pkg::K_PUT:
                        begin
                            if (col_reg == COL_END)
                            begin
                                if (row_reg != ROW_LAST)
                                begin
                                    // wrap onto the next row, write at its start
                                    we            = 1'b1;
                                    waddr         = row_base_reg + COLS_A;
                                    wdata         = {cmd.char_code, text_color};
                                    row_next      = row_reg + 1'b1;
                                    row_base_next = row_base_reg + COLS_A;
                                    col_next      = CW'(1);
                                    load          = 1'b1;
                                end
                                else
                                begin
                                    // wrap on the last row: scroll, then write
                                    col_next       = '0;
                                    pend_next      = 1'b1;
                                    pend_char_next = cmd.char_code;
                                    resp_char_next = 8'd0;
                                    resp_attr_next = 8'd0;
                                    cnt_next       = '0;
                                    state_next     = S_COPY;
                                end
                            end
                            else
                            begin
                                we       = 1'b1;
                                waddr    = row_base_reg + AW'(col_reg);
                                wdata    = {cmd.char_code, text_color};
                                col_next = col_reg + 1'b1;
                                load     = 1'b1;
                            end
                        end
                        tcw_pkg::K_NEWLINE:
                        begin
                            col_next = '0;
                            if (row_reg != ROW_LAST)
                            begin
                                row_next      = row_reg + 1'b1;
                                row_base_next = row_base_reg + COLS_A;
                                load          = 1'b1;
                            end
                            else
                            begin
                                pend_next      = 1'b0;
                                resp_char_next = 8'd0;
                                resp_attr_next = 8'd0;
                                cnt_next       = '0;
                                state_next     = S_COPY;
                            end
                        end
                        tcw_pkg::K_CLEAR:
                        begin
                            resp_char_next = 8'd0;
                            resp_attr_next = 8'd0;
                            cnt_next       = '0;
                            state_next     = S_CLEAR;
                        end
                        tcw_pkg::K_READ:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                resp_char_next = rd_data_reg[15:8];
                resp_attr_next = rd_data_reg[7:0];
                state_next     = S_RESP;
            end
            S_CLEAR:
            begin
                we = 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_COPY:
            begin
                // read the cell one row below; written back next cycle
                raddr        = cnt_reg + COLS_A;
                cp_vld_next  = 1'b1;
                cp_addr_next = cnt_reg;
                if (cnt_reg == SPAN_LAST)
                begin
                    state_next = S_COPY_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_COPY_LAST:
            begin
                cnt_next   = BOTTOM_BASE;
                state_next = S_BLANK;
            end
            S_BLANK:
            begin
                we = 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = pend_reg ? S_PEND : S_RESP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_PEND:
            begin
                we         = 1'b1;
                waddr      = row_base_reg;
                wdata      = {pend_char_reg, text_color};
                col_next   = CW'(1);
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    ld_char    = resp_char_reg;
                    ld_attr    = resp_attr_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Load or drain the result register
    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_char_next = out_char_reg;
        out_attr_next = out_attr_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        if (load)
        begin
            out_vld_next  = 1'b1;
            out_char_next = ld_char;
            out_attr_next = ld_attr;
            out_row_next  = 5'(row_next);
            out_col_next  = 7'(col_next);
        end
        else if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            row_reg      <= '0;
            col_reg      <= '0;
            row_base_reg <= '0;
            cnt_reg      <= '0;
            cp_vld_reg   <= 1'b0;
            pend_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            row_base_reg <= row_base_next;
            cnt_reg      <= cnt_next;
            cp_vld_reg   <= cp_vld_next;
            pend_reg     <= pend_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        cp_addr_reg   <= cp_addr_next;
        pend_char_reg <= pend_char_next;
        resp_char_reg <= resp_char_next;
        resp_attr_reg <= resp_attr_next;
        out_char_reg  <= out_char_next;
        out_attr_reg  <= out_attr_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
    end

    // Cell store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    // Cursor column stays within the row, pending wrap included
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_END)
        else $error("cursor column beyond row end");

    // Cursor row stays on screen
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= ROW_LAST)
        else $error("cursor row beyond last row");

    // Row base tracks the cursor row
    a_row_base: assert property (@(posedge clk) disable iff (!rst_n)
        row_base_reg == AW'(row_reg) * COLS_A)
        else $error("row base out of step with cursor row");

    // Copy write-back happens only inside a scroll copy
    a_copy_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        cp_vld_reg |-> (state_reg == S_COPY || state_reg == S_COPY_LAST))
        else $error("copy write-back outside scroll");

endmodule

`default_nettype wire

// File: hw/rtl/text_console_writer.sv
// ============================================================================
// text_console_writer
// Text console over a ROWS x COLUMNS cell store of character/color bytes.
//
// Request channel (req_valid/req_stall): op, char_code, read_row, read_col.
// Result channel (rsp_valid/rsp_stall): cell_char, cell_attr, cursor_row,
// cursor_col; exactly one result per request, in order.
// APB port: text_color at byte address 0, written with the screen idle.
// A newline on the last row scrolls: a copy of ROWS-1 rows, then a blank
// bottom row; a wrapped character on the last row is then written onto
// the fresh bottom row. A clear blanks every cell.
// Throughput: plain characters run at one per cycle while results are
// not stalled, set by the single write port of the cell store; scroll
// and clear walk it one cell a cycle.
// Reset: the cursor goes to row 0, column 0 and a clearing pass writes
// blank cells with color 0x0F over all ROWS*COLUMNS cells (2000 at 80x25),
// holding req_stall high throughout.
// A stalled result holds in the output register; the two-entry command
// queue and the front-end stage keep taking requests until both fill,
// then req_stall rises.
// ============================================================================
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // request channel
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire logic [1:0]    op,
    input  wire logic [7:0]    char_code,
    input  wire logic [4:0]    read_row,
    input  wire logic [6:0]    read_col,
    // result channel
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output logic [7:0]         cell_char,
    output logic [7:0]         cell_attr,
    output logic [4:0]         cursor_row,
    output logic [6:0]         cursor_col,
    // configuration port
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [1:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [7:0]     text_color_reg;
    logic [7:0]     text_color_next;
    logic           cfg_wr;
    logic           init_busy;
    logic           queue_full;
    logic           queue_push;
    logic           queue_pop;
    logic           queue_not_empty;
    tcw_pkg::cmd_t  push_cmd;
    tcw_pkg::cmd_t  head_cmd;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr == tcw_pkg::ADDR_TEXT_COLOR);
    assign prdata = (paddr == tcw_pkg::ADDR_TEXT_COLOR) ? {24'd0, text_color_reg}
                                                        : 32'd0;

    always_comb
    begin
        text_color_next = text_color_reg;
        if (cfg_wr)
        begin
            text_color_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= tcw_pkg::RESET_COLOR;
        end
        else
        begin
            text_color_reg <= text_color_next;
        end
    end

    tcw_front #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (req_valid),
        .stall      (req_stall),
        .op         (op),
        .char_code  (char_code),
        .read_row   (read_row),
        .read_col   (read_col),
        .hold       (init_busy),
        .queue_full (queue_full),
        .push       (queue_push),
        .push_cmd   (push_cmd)
    );

    tcw_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (queue_push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (queue_pop),
        .head_cmd   (head_cmd),
        .not_empty  (queue_not_empty)
    );

    tcw_back #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (head_cmd),
        .cmd_vld    (queue_not_empty),
        .cmd_pop    (queue_pop),
        .text_color (text_color_reg),
        .init_busy  (init_busy),
        .out_valid  (rsp_valid),
        .out_stall  (rsp_stall),
        .cell_char  (cell_char),
        .cell_attr  (cell_attr),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col)
    );

endmodule

`default_nettype wire

// File: bench/tcw_screen_checker.sv
// ============================================================================
// tcw_screen_checker
// Watches the request, result and APB channels of the text console writer.
// Keeps its own copy of the screen, cursor and text color, works out the
// result of every accepted item and compares it field by field with the
// result that the block delivers, in order.
// ============================================================================
module tcw_screen_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  char_code,
    input  logic [4:0]  read_row,
    input  logic [6:0]  read_col,
    // result channel
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [7:0]  cell_char,
    input  logic [7:0]  cell_attr,
    input  logic [4:0]  cursor_row,
    input  logic [6:0]  cursor_col,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    // status toward the bench top
    output int          mismatch_count,
    output int          outstanding,
    output int          results_checked,
    output int          scroll_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] attr;
        logic [4:0] row;
        logic [6:0] col;
    } cell_result_t;

    // Shadow screen, cursor and color
    logic [7:0]   glyph [ROWS][COLUMNS];
    logic [7:0]   shade [ROWS][COLUMNS];
    int           cur_row;
    int           cur_col;
    logic [7:0]   text_color;
    cell_result_t expected_q[$];

    function automatic void blank_line(input int r);
        for (int c = 0; c < COLUMNS; c++) begin
            glyph[r][c] = tcw_pkg::BLANK_CODE;
            shade[r][c] = text_color;
        end
    endfunction

    // Move to the next line, scrolling the screen up on the last row
    function automatic void line_feed();
        cur_col = 0;
        if (cur_row < ROWS - 1) begin
            cur_row++;
        end
        else begin
            for (int r = 0; r < ROWS - 1; r++) begin
                for (int c = 0; c < COLUMNS; c++) begin
                    glyph[r][c] = glyph[r + 1][c];
                    shade[r][c] = shade[r + 1][c];
                end
            end
            blank_line(ROWS - 1);
            scroll_count++;
        end
    endfunction

    // Apply one item to the shadow screen and return its result
    function automatic cell_result_t apply_command(input logic [1:0] cmd,
                                                   input logic [7:0] code,
                                                   input logic [4:0] rr,
                                                   input logic [6:0] rc);
        cell_result_t res;
        res = '0;
        case (cmd)
            tcw_pkg::OP_PUT: begin
                if (code == tcw_pkg::NEWLINE_CODE) begin
                    line_feed();
                end
                else begin
                    // wrap first when the column has run off the line
                    if (cur_col >= COLUMNS)
                        line_feed();
                    glyph[cur_row][cur_col] = code;
                    shade[cur_row][cur_col] = text_color;
                    cur_col++;
                end
            end
            tcw_pkg::OP_CLEAR: begin
                for (int r = 0; r < ROWS; r++)
                    blank_line(r);
            end
            tcw_pkg::OP_READ: begin
                // reads off the screen return zeros
                if (rr < ROWS && rc < COLUMNS) begin
                    res.ch   = glyph[rr][rc];
                    res.attr = shade[rr][rc];
                end
            end
            default: ;
        endcase
        res.row = cur_row[4:0];
        res.col = cur_col[6:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("MISMATCH at %0t ns, result %0d, %s: got %0d expected %0d",
                     $time, results_checked, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n) begin
        cell_result_t want;
        if (!rst_n) begin
            // drop all state back to a blank screen
            text_color = tcw_pkg::RESET_COLOR;
            for (int r = 0; r < ROWS; r++)
                blank_line(r);
            cur_row = 0;
            cur_col = 0;
            expected_q.delete();
            mismatch_count  = 0;
            results_checked = 0;
            scroll_count    = 0;
            outstanding <= 0;
        end
        else begin
            // track register writes
            if (psel && penable && pwrite && pready && paddr == tcw_pkg::ADDR_TEXT_COLOR)
                text_color = pwdata[7:0];

            // compare a delivered result with the oldest expectation
            if (rsp_valid && !rsp_stall) begin
                results_checked++;
                if (expected_q.size() == 0) begin
                    report_mismatch("result with no item pending", cell_char, -1);
                end
                else begin
                    want = expected_q.pop_front();
                    if (cell_char !== want.ch)
                        report_mismatch("cell_char", cell_char, want.ch);
                    if (cell_attr !== want.attr)
                        report_mismatch("cell_attr", cell_attr, want.attr);
                    if (cursor_row !== want.row)
                        report_mismatch("cursor_row", cursor_row, want.row);
                    if (cursor_col !== want.col)
                        report_mismatch("cursor_col", cursor_col, want.col);
                end
            end

            // predict an accepted item
            if (req_valid && !req_stall)
                expected_q.push_back(apply_command(op, char_code, read_row, read_col));

            outstanding <= expected_q.size();
        end
    end

endmodule

// File: bench/tb_text_console_writer.sv
// ============================================================================
// tb_text_console_writer
// Drives the text console writer with a short directed sequence and then
// random text: characters, newlines, clears, cell reads and unused ops, under
// several text colors and idle mixes, with a long result hold-off. A checker
// beside the block predicts and compares every result.
// ============================================================================
module tb_text_console_writer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam int         QUIET_LIMIT     = 20000;
    localparam int         HOLD_CYCLES     = 400;
    localparam int         ITEMS_PER_PHASE = 660;

    logic        clk;
    logic        rst_n;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [1:0]  op        = '0;
    logic [7:0]  char_code = '0;
    logic [4:0]  read_row  = '0;
    logic [6:0]  read_col  = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [1:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatch_count;
    int outstanding;
    int results_checked;
    int scroll_count;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int items_sent    = 0;
    int clears_sent   = 0;

    text_console_writer dut (.*);

    tcw_screen_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .op             (op),
        .char_code      (char_code),
        .read_row       (read_row),
        .read_col       (read_col),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .cell_char      (cell_char),
        .cell_attr      (cell_attr),
        .cursor_row     (cursor_row),
        .cursor_col     (cursor_col),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .results_checked(results_checked),
        .scroll_count   (scroll_count)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stall the result channel at random, or hold it off for a long stretch
    initial begin : result_backpressure
        int served;
        served = 0;
        forever begin
            @(posedge clk);
            if (served != hold_requests) begin
                served++;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else begin
                rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
            end
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Write the text color over APB: setup cycle, then access cycle
    task automatic write_color(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tcw_pkg::ADDR_TEXT_COLOR;
        pwdata  <= ($urandom() & 32'hFFFF_FF00) | {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one item, with an optional idle gap first, and wait for acceptance
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] code,
                             input logic [4:0] rr, input logic [6:0] rc);
        int gap;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            gap = ($urandom_range(19) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        op        <= cmd;
        char_code <= code;
        read_row  <= rr;
        read_col  <= rc;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        items_sent++;
        if (cmd == tcw_pkg::OP_CLEAR)
            clears_sent++;
    endtask

    // Mostly running text with reads near the cursor; rare clears and noise
    task automatic send_random_item();
        int pick;
        int hint;
        logic [7:0] code;
        logic [4:0] rr;
        logic [6:0] rc;
        pick = $urandom_range(999);
        code = 8'($urandom_range(255));
        rr   = 5'($urandom_range(31));
        rc   = 7'($urandom_range(127));
        if (pick < 5) begin
            send_item(tcw_pkg::OP_CLEAR, code, rr, rc);
        end
        else if (pick < 20) begin
            send_item(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, rr, rc);
        end
        else if (pick < 35) begin
            send_item(OP_UNUSED, code, rr, rc);
        end
        else if (pick < 235) begin
            // aim most reads at rows just written; keep some fully random
            if ($urandom_range(9) != 0) begin
                hint = int'(cursor_row);
                if (hint >= tcw_pkg::ROWS_DEF || $urandom_range(1) == 0)
                    rr = 5'($urandom_range(tcw_pkg::ROWS_DEF - 1));
                else
                    rr = (hint >= 2) ? 5'(hint - int'($urandom_range(2)))
                                     : 5'($urandom_range(hint));
                rc = 7'($urandom_range(tcw_pkg::COLUMNS_DEF - 1));
            end
            send_item(tcw_pkg::OP_READ, code, rr, rc);
        end
        else begin
            send_item(tcw_pkg::OP_PUT, code, rr, rc);
        end
    endtask

    // Wait until every predicted result has come back, then let the block settle
    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_phase(input logic [7:0] color, input int idle_pct,
                             input int stall, input bit pressure);
        write_color(color);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // hold the result side off while items keep coming
            if (pressure && i == ITEMS_PER_PHASE / 3)
                hold_requests++;
            // pause the sender until the block has drained
            if (pressure && i == 2 * ITEMS_PER_PHASE / 3) begin
                req_valid <= 1'b0;
                wait_drained();
            end
            send_random_item();
        end
        req_valid <= 1'b0;
        wait_drained();
    endtask

    initial begin : stimulus
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // wait out the power-up clearing pass
        @(posedge clk);
        while (req_stall) @(posedge clk);

        // directed: field extremes, every op, off-screen reads, clear color
        write_color(8'h1E);
        send_item(tcw_pkg::OP_PUT,   8'h41, '0, '0);
        send_item(tcw_pkg::OP_PUT,   8'h00, '0, '0);
        send_item(tcw_pkg::OP_PUT,   8'hFF, '0, '0);
        send_item(tcw_pkg::OP_READ,  8'h00, 5'd0,  7'd0);
        send_item(tcw_pkg::OP_READ,  8'h00, 5'd0,  7'd2);
        send_item(tcw_pkg::OP_READ,  8'h00, 5'd24, 7'd79);
        send_item(tcw_pkg::OP_READ,  8'hFF, 5'd31, 7'd127);
        send_item(tcw_pkg::OP_READ,  8'h00, 5'd25, 7'd0);
        send_item(tcw_pkg::OP_READ,  8'h00, 5'd0,  7'd80);
        send_item(OP_UNUSED,         8'hFF, 5'd31, 7'd127);
        send_item(tcw_pkg::OP_PUT,   tcw_pkg::NEWLINE_CODE, '0, '0);
        send_item(tcw_pkg::OP_PUT,   8'h7E, '0, '0);
        send_item(tcw_pkg::OP_READ,  8'h00, 5'd1,  7'd0);
        send_item(tcw_pkg::OP_CLEAR, 8'h00, '0, '0);
        send_item(tcw_pkg::OP_READ,  8'h00, 5'd0,  7'd0);
        send_item(tcw_pkg::OP_READ,  8'h00, 5'd1,  7'd0);
        send_item(tcw_pkg::OP_PUT,   tcw_pkg::NEWLINE_CODE, '0, '0);
        send_item(tcw_pkg::OP_READ,  8'h00, 5'd2,  7'd0);
        req_valid <= 1'b0;
        wait_drained();

        // random text under several colors and idle mixes
        run_phase(8'h00, 28, 58, 1'b0);
        run_phase(8'hFF, 58, 28, 1'b0);
        run_phase(8'($urandom_range(1, 254)), 0, 0, 1'b1);

        // let any stray result show up
        repeat (20) @(posedge clk);

        $display("Covered %0d items (%0d clears) under four text colors and three idle mixes,",
                 items_sent, clears_sent);
        $display("with %0d results checked, %0d scrolls and one long result hold-off.",
                 results_checked, scroll_count);
        if (mismatch_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_cmd_queue.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer.sv
bench/tcw_screen_checker.sv
bench/tb_text_console_writer.sv
